// File: src/sorted_deadline_timer_queue_macros.svh
// Assertion macros for the sorted deadline timer queue checkers
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDTQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sdtq: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define SDTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sdtq: next-cycle check failed");

`endif

// File: src/sdtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdtq_pkg;

	// Results emitted per tick request at most
	localparam int unsigned MAX_OUT = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_TICK_CHECK,
		ST_TICK_READ,
		ST_EMIT
	} state_t;

	// One stored timer
	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  id;
	} entry_t;

	// Ticks left until a deadline, saturated to 16 bits, zero when overdue or empty
	function automatic logic [15:0] front_wait(input logic [31:0] deadline,
		input logic [31:0] now, input logic nonempty);
		logic [31:0] gap;
		gap = deadline - now;
		if (!nonempty || gap[31])
			return 16'd0;
		if (gap[31:16] != 16'd0)
			return 16'hFFFF;
		return gap[15:0];
	endfunction

endpackage

`default_nettype wire

// File: src/sorted_deadline_timer_queue.sv
// Schedule request: a zero delay or a full queue is answered from ST_EMIT with no insert;
//   an insert moves back by one slot each of the k entries behind the new timer (k up to QUEUE_DEPTH - 1).
// Tick request: each expired timer goes through ST_TICK_CHECK and ST_TICK_READ, and a burst closes in
//   ST_EMIT; ST_TICK_READ takes the registered memory read that refreshes the queue front.
// One request is handled at a time; the output register lets the next one be taken.
// Reset (arst_n low) empties the queue and clears the time counter; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_deadline_timer_queue #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [15:0] delay_ticks,
	input  wire logic [7:0]  callback_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             fired,
	output logic [7:0]       fired_id,
	output logic [15:0]      wait_left,
	output logic             full_error,
	output logic             last
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned NW = $clog2(sdtq_pkg::MAX_OUT + 1);

	// Entry memory, circular with head_q at logical slot 0
	sdtq_pkg::entry_t entry_mem_q [QUEUE_DEPTH];

	sdtq_pkg::state_t state_q, state_d;

	logic [31:0]   now_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic          pend_v_q;
	logic          out_valid_q;

	logic [15:0]   req_delay_q;
	logic [7:0]    req_id_q;
	logic [31:0]   front_dl_q;
	logic [7:0]    front_id_q;
	sdtq_pkg::entry_t rd_q;

	logic          pend_fired_q;
	logic [7:0]    pend_id_q;
	logic [15:0]   pend_wait_q;
	logic          pend_err_q;

	logic          fired_q;
	logic [7:0]    fired_id_q;
	logic [15:0]   wait_left_q;
	logic          full_error_q;
	logic          last_q;

	// Control strobes
	logic          accept;
	logic          slot_free;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	sdtq_pkg::entry_t wr_data;
	logic          ins_done;
	logic          pop;
	logic          load_out;

	// Decision terms
	logic [31:0]   new_dl;
	logic [31:0]   rd_dist;
	logic          shift_more;
	logic [31:0]   front_dist;
	logic          more;
	logic          full;

	// Logical slot to physical address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, head} + (AW + 1)'(k);
		if (s >= (AW + 1)'(QUEUE_DEPTH))
			s = s - (AW + 1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full      = count_q >= CW'(QUEUE_DEPTH);
	assign new_dl    = now_q + {16'd0, req_delay_q};

	// Insert scan: the entry just read moves back when it is due after the new timer
	assign rd_dist    = rd_q.deadline - now_q;
	assign shift_more = (idx_q != '0) && !rd_dist[31] && (rd_dist > {16'd0, req_delay_q});

	// Expiry check on the cached front entry
	assign front_dist = front_dl_q - now_q;
	assign more       = (count_q != '0) && (n_q < NW'(sdtq_pkg::MAX_OUT))
		&& ((front_dist == 32'd0) || front_dist[31]);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdtq_pkg::ST_IDLE: begin
				if (accept) begin
					if (kind)
						state_d = sdtq_pkg::ST_TICK_CHECK;
					else if ((delay_ticks == 16'd0) || full)
						state_d = sdtq_pkg::ST_EMIT;
					else
						state_d = sdtq_pkg::ST_INSERT;
				end
			end
			sdtq_pkg::ST_INSERT: begin
				if (!shift_more)
					state_d = sdtq_pkg::ST_EMIT;
			end
			sdtq_pkg::ST_TICK_CHECK: begin
				if (more) begin
					if (!pend_v_q || slot_free)
						state_d = sdtq_pkg::ST_TICK_READ;
				end else if (pend_v_q) begin
					state_d = sdtq_pkg::ST_EMIT;
				end else begin
					state_d = sdtq_pkg::ST_IDLE;
				end
			end
			sdtq_pkg::ST_TICK_READ: begin
				state_d = sdtq_pkg::ST_TICK_CHECK;
			end
			sdtq_pkg::ST_EMIT: begin
				if (slot_free)
					state_d = sdtq_pkg::ST_IDLE;
			end
			default: state_d = sdtq_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = phys(head_q, idx_q);
		wr_data  = rd_q;
		ins_done = 1'b0;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			sdtq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = accept && !kind && (delay_ticks != 16'd0) && !full
					&& (count_q != '0);
				rd_addr  = phys(head_q, count_q - CW'(1));
			end
			sdtq_pkg::ST_INSERT: begin
				wr_en = 1'b1;
				if (shift_more) begin
					rd_en   = idx_q >= CW'(2);
					rd_addr = phys(head_q, idx_q - CW'(2));
				end else begin
					wr_data.deadline = new_dl;
					wr_data.id       = req_id_q;
					ins_done         = 1'b1;
				end
			end
			sdtq_pkg::ST_TICK_CHECK: begin
				if (more && (!pend_v_q || slot_free)) begin
					pop      = 1'b1;
					load_out = pend_v_q;
					rd_en    = count_q > CW'(1);
					rd_addr  = phys(head_q, CW'(1));
				end
			end
			sdtq_pkg::ST_TICK_READ: begin
			end
			sdtq_pkg::ST_EMIT: begin
				load_out = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			entry_mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= entry_mem_q[rd_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdtq_pkg::ST_IDLE;
			now_q       <= '0;
			count_q     <= '0;
			head_q      <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= count_q;
				if (kind) begin
					now_q    <= now_q + 32'd1;
					n_q      <= '0;
					pend_v_q <= 1'b0;
				end
			end
			if ((state_q == sdtq_pkg::ST_INSERT) && shift_more)
				idx_q <= idx_q - CW'(1);
			if (ins_done)
				count_q <= count_q + CW'(1);
			if (pop) begin
				head_q   <= phys(head_q, CW'(1));
				count_q  <= count_q - CW'(1);
				n_q      <= n_q + NW'(1);
				pend_v_q <= 1'b1;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Request, front cache, pending result and output payload
	always_ff @(posedge clk) begin
		if (accept && !kind) begin
			req_delay_q <= delay_ticks;
			req_id_q    <= callback_id;
			if (delay_ticks == 16'd0) begin
				pend_fired_q <= 1'b1;
				pend_id_q    <= callback_id;
				pend_wait_q  <= 16'd0;
				pend_err_q   <= 1'b0;
			end else if (full) begin
				pend_fired_q <= 1'b0;
				pend_id_q    <= 8'd0;
				pend_wait_q  <= sdtq_pkg::front_wait(front_dl_q, now_q, count_q != '0);
				pend_err_q   <= 1'b1;
			end
		end
		if (ins_done) begin
			pend_fired_q <= 1'b0;
			pend_id_q    <= 8'd0;
			pend_err_q   <= 1'b0;
			if (idx_q == '0) begin
				front_dl_q  <= new_dl;
				front_id_q  <= req_id_q;
				pend_wait_q <= sdtq_pkg::front_wait(new_dl, now_q, 1'b1);
			end else begin
				pend_wait_q <= sdtq_pkg::front_wait(front_dl_q, now_q, 1'b1);
			end
		end
		if (pop) begin
			pend_fired_q <= 1'b1;
			pend_id_q    <= front_id_q;
			pend_wait_q  <= 16'd0;
			pend_err_q   <= 1'b0;
		end
		if (state_q == sdtq_pkg::ST_TICK_READ) begin
			front_dl_q <= rd_q.deadline;
			front_id_q <= rd_q.id;
		end
		if (load_out) begin
			fired_q      <= pend_fired_q;
			fired_id_q   <= pend_id_q;
			wait_left_q  <= pend_wait_q;
			full_error_q <= pend_err_q;
			last_q       <= (state_q == sdtq_pkg::ST_EMIT);
		end
	end

	assign out_valid  = out_valid_q;
	assign fired      = fired_q;
	assign fired_id   = fired_id_q;
	assign wait_left  = wait_left_q;
	assign full_error = full_error_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// File: src/sdtq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_deadline_timer_queue_macros.svh"

module sdtq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        fired,
	input wire logic [15:0] wait_left,
	input wire logic        full_error,
	input wire logic        last
);

	// An expired timer never carries a wait time or an error flag
	`SDTQ_ASSERT_IMPLY(a_fired_clean, clk, arst_n, out_valid && fired, (wait_left == 16'd0) && !full_error)

	// A refused schedule is always a single, final result
	`SDTQ_ASSERT_IMPLY(a_full_is_last, clk, arst_n, out_valid && full_error, last)

	// While a burst of expiries is still open, no new request is taken
	`SDTQ_ASSERT_IMPLY(a_burst_blocks_input, clk, arst_n, out_valid && !last, !in_ready)

	// A result not yet taken stays offered
	`SDTQ_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.fired      (fired),
	.wait_left  (wait_left),
	.full_error (full_error),
	.last       (last)
);

`default_nettype wire

// File: tb/sorted_deadline_timer_queue_test.sv
`timescale 1ns / 1ps

module sorted_deadline_timer_queue_test;

	localparam int unsigned QUEUE_DEPTH  = 16;
	localparam int unsigned BURST_MAX    = sdtq_pkg::MAX_OUT;
	localparam int          RANDOM_ITEMS = 140;
	localparam int          QUIET_TAIL   = 30;   // last requests sent with no idling
	localparam int          TAIL_CYCLES  = 60;
	localparam int          STALL_LIMIT  = 4000;

	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_TICK     = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] delay_ticks;
		logic [7:0]  callback_id;
	} timer_request_t;

	typedef struct packed {
		logic        fired;
		logic [7:0]  fired_id;
		logic [15:0] wait_left;
		logic        full_error;
		logic        last;
	} timer_result_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        kind        = 1'b0;
	logic [15:0] delay_ticks = 16'd0;
	logic [7:0]  callback_id = 8'd0;
	logic        out_ready   = 1'b0;
	wire logic        in_ready;
	wire logic        out_valid;
	wire logic        fired;
	wire logic [7:0]  fired_id;
	wire logic [15:0] wait_left;
	wire logic        full_error;
	wire logic        last;

	sorted_deadline_timer_queue i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.delay_ticks(delay_ticks),
		.callback_id(callback_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fired      (fired),
		.fired_id   (fired_id),
		.wait_left  (wait_left),
		.full_error (full_error),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Timer queue mirror
	logic [31:0] tq_now = 32'd0;
	logic [31:0] tq_deadline [QUEUE_DEPTH];
	logic [7:0]  tq_id [QUEUE_DEPTH];
	int          tq_count = 0;

	timer_request_t pending_requests[$];
	timer_result_t  due_results[$];

	int issued_count   = 0;
	int accepted_count = 0;
	int results_seen   = 0;
	int fired_seen     = 0;
	int refused_seen   = 0;
	int fail_count     = 0;
	int quiet_cycles   = 0;
	int send_gap       = 0;
	int recv_gap       = 0;
	bit stalled        = 1'b0;
	timer_request_t next_request;
	timer_result_t  got_result;
	timer_result_t  want_result;

	// Ticks until the front deadline, saturated, zero when overdue or empty
	function automatic logic [15:0] ticks_to_front();
		logic [31:0] gap;
		if (tq_count == 0)
			return 16'd0;
		gap = tq_deadline[0] - tq_now;
		if (gap[31])
			return 16'd0;
		if (gap[31:16] != 16'd0)
			return 16'hFFFF;
		return gap[15:0];
	endfunction

	// Apply one accepted request to the mirror and queue the results it causes
	task automatic predict_request(input logic k, input logic [15:0] dly, input logic [7:0] cid);
		timer_result_t r;
		timer_result_t burst [BURST_MAX];
		logic [31:0]   gap;
		int            pos;
		int            i;
		int            n;
		r = '0;
		if (k == KIND_SCHEDULE) begin
			r.last = 1'b1;
			if (dly == 16'd0) begin
				r.fired = 1'b1;
				r.fired_id = cid;
			end else if (tq_count >= QUEUE_DEPTH) begin
				r.full_error = 1'b1;
				r.wait_left = ticks_to_front();
			end else begin
				// ties land behind the timers already stored
				pos = 0;
				while (pos < tq_count) begin
					gap = tq_deadline[pos] - tq_now;
					if (!gap[31] && gap > {16'd0, dly})
						break;
					pos++;
				end
				for (i = tq_count; i > pos; i--) begin
					tq_deadline[i] = tq_deadline[i - 1];
					tq_id[i] = tq_id[i - 1];
				end
				tq_deadline[pos] = tq_now + {16'd0, dly};
				tq_id[pos] = cid;
				tq_count++;
				r.wait_left = ticks_to_front();
			end
			due_results.push_back(r);
		end else begin
			tq_now = tq_now + 32'd1;
			n = 0;
			while (tq_count > 0 && n < BURST_MAX) begin
				gap = tq_deadline[0] - tq_now;
				if (gap != 32'd0 && !gap[31])
					break;
				burst[n] = '0;
				burst[n].fired = 1'b1;
				burst[n].fired_id = tq_id[0];
				n++;
				for (i = 1; i < tq_count; i++) begin
					tq_deadline[i - 1] = tq_deadline[i];
					tq_id[i - 1] = tq_id[i];
				end
				tq_count--;
			end
			if (n > 0)
				burst[n - 1].last = 1'b1;
			for (i = 0; i < n; i++)
				due_results.push_back(burst[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic push_request(input logic k, input logic [15:0] dly, input logic [7:0] cid);
		timer_request_t req;
		req.kind = k;
		req.delay_ticks = dly;
		req.callback_id = cid;
		pending_requests.push_back(req);
	endtask

	// Request driver: holds a request until taken, idles in random bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && issued_count != accepted_count) begin
				// keep the request on the bus
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else begin
					next_request = pending_requests.pop_front();
					in_valid <= 1'b1;
					kind <= next_request.kind;
					delay_ticks <= next_request.delay_ticks;
					callback_id <= next_request.callback_id;
					issued_count <= issued_count + 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
				recv_gap <= $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on accepted requests, check accepted results, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_request(kind, delay_ticks, callback_id);
				accepted_count <= accepted_count + 1;
			end
			if (out_valid && out_ready) begin
				got_result.fired = fired;
				got_result.fired_id = fired_id;
				got_result.wait_left = wait_left;
				got_result.full_error = full_error;
				got_result.last = last;
				results_seen++;
				if (fired)
					fired_seen++;
				if (full_error)
					refused_seen++;
				if (due_results.size() == 0) begin
					$error("result with nothing expected: fired=%0d fired_id=%0d wait_left=%0d",
						fired, fired_id, wait_left);
					fail_count++;
				end else begin
					want_result = due_results.pop_front();
					check_field("fired", 16'(want_result.fired), 16'(got_result.fired));
					check_field("fired_id", 16'(want_result.fired_id), 16'(got_result.fired_id));
					check_field("wait_left", want_result.wait_left, got_result.wait_left);
					check_field("full_error", 16'(want_result.full_error),
						16'(got_result.full_error));
					check_field("last", 16'(want_result.last), 16'(got_result.last));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT)
				stalled = 1'b1;
		end
	end

	// Stimulus and end of run
	initial begin
		int j;
		int n;
		int pick;
		int sel;
		int directed_count;
		logic        k;
		logic [15:0] dly;

		// tick on an empty queue, immediate fires, longest delay
		push_request(KIND_TICK, 16'h0000, 8'h00);
		push_request(KIND_SCHEDULE, 16'd0, 8'hFF);
		push_request(KIND_SCHEDULE, 16'd0, 8'h00);
		push_request(KIND_SCHEDULE, 16'hFFFF, 8'hA5);
		// equal deadlines ahead of the long one, filling the queue
		for (j = 0; j < QUEUE_DEPTH - 1; j++)
			push_request(KIND_SCHEDULE, 16'd2, 8'(8'h10 + j));
		// refused on a full queue
		push_request(KIND_SCHEDULE, 16'd1, 8'h5A);
		// the second tick expires nothing, the third expires the whole batch of ties
		push_request(KIND_TICK, 16'hFFFF, 8'hFF);
		push_request(KIND_TICK, 16'h0000, 8'h00);
		directed_count = pending_requests.size();

		while (pending_requests.size() < directed_count + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// a few timers, then enough ticks to expire some of them
				n = $urandom_range(1, 8);
				repeat (n) push_request(KIND_SCHEDULE, 16'($urandom_range(1, 10)), 8'($urandom));
				n = $urandom_range(1, 12);
				repeat (n) push_request(KIND_TICK, 16'($urandom), 8'($urandom));
			end else if (pick < 8) begin
				// overfill, then drain
				n = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3);
				repeat (n) push_request(KIND_SCHEDULE, 16'($urandom_range(1, 4)), 8'($urandom));
				repeat (6) push_request(KIND_TICK, 16'($urandom), 8'($urandom));
			end else begin
				// noise
				n = $urandom_range(1, 6);
				repeat (n) begin
					k = 1'($urandom_range(0, 1));
					sel = $urandom_range(0, 19);
					if (sel == 0)
						dly = 16'($urandom);
					else if (sel < 4)
						dly = 16'd0;
					else
						dly = 16'($urandom_range(1, 20));
					push_request(k, dly, 8'($urandom));
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!stalled && !(pending_requests.size() == 0 && issued_count == accepted_count
				&& due_results.size() == 0))
			@(negedge clk);
		if (!stalled)
			repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d requests (%0d directed), checked %0d results: %0d fired, %0d refused",
			accepted_count, directed_count, results_seen, fired_seen, refused_seen);
		if (stalled) begin
			$error("no progress for %0d cycles, %0d results still expected",
				STALL_LIMIT, due_results.size());
			$display("Regression FAIL");
		end else begin
			if (fail_count == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
		end
		$finish;
	end

endmodule
